@@ sv/wit_pkg.sv @@
`timescale 1ns / 1ps

package wit_pkg;

  localparam int unsigned TimeBits = 32;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_CHECK   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [TimeBits-1:0] now_ms;
    logic [TimeBits-1:0] delay_ms;
  } in_beat_t;

  typedef struct packed {
    logic fired;
    logic expired_read;
    logic running;
  } out_beat_t;

endpackage

@@ sv/wit_core.sv @@
`timescale 1ns / 1ps

module wit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               periodic_i,
  input  logic               step_i,
  input  wit_pkg::in_beat_t  beat_i,
  output wit_pkg::out_beat_t res_o
);
  import wit_pkg::*;

  logic                run_q, run_d;
  logic                exp_q, exp_d;
  logic [TimeBits-1:0] trig_q, trig_d;
  logic [TimeBits-1:0] limit_q, limit_d;
  logic [TimeBits-1:0] delay_q, delay_d;

  logic [TimeBits-1:0] now;
  logic [TimeBits-1:0] arm_delay;
  logic [TimeBits-1:0] room;
  logic [TimeBits-1:0] arm_trig;
  logic [TimeBits-1:0] arm_limit;
  logic                hit;

  assign now       = beat_i.now_ms;
  assign arm_delay = (beat_i.cmd == CMD_START) ? beat_i.delay_ms : delay_q;
  assign room      = TimeMax - now;

  always_comb begin
    if (room < arm_delay) begin
      arm_trig  = arm_delay - room - TimeBits'(1);
      arm_limit = now;
    end else begin
      arm_trig  = now + arm_delay - TimeBits'(1);
      arm_limit = TimeMax;
    end
  end

  assign hit = run_q && (trig_q < now) && (now < limit_q);

  always_comb begin
    run_d   = run_q;
    exp_d   = exp_q;
    trig_d  = trig_q;
    limit_d = limit_q;
    delay_d = delay_q;
    res_o   = '0;
    unique case (beat_i.cmd)
      CMD_TICK, CMD_CHECK: begin
        if (hit) begin
          res_o.fired = 1'b1;
          exp_d       = 1'b1;
          if (periodic_i) begin
            trig_d  = arm_trig;
            limit_d = arm_limit;
          end else begin
            run_d = 1'b0;
          end
        end
        if (beat_i.cmd == CMD_CHECK) begin
          res_o.expired_read = exp_d;
          exp_d              = 1'b0;
        end
      end
      CMD_START, CMD_RESTART: begin
        delay_d = arm_delay;
        run_d   = 1'b1;
        trig_d  = arm_trig;
        limit_d = arm_limit;
      end
      CMD_CANCEL: begin
        run_d = 1'b0;
        exp_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_o.running = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      exp_q   <= 1'b0;
      trig_q  <= '0;
      limit_q <= TimeMax;
      delay_q <= '0;
    end else if (step_i) begin
      run_q   <= run_d;
      exp_q   <= exp_d;
      trig_q  <= trig_d;
      limit_q <= limit_d;
      delay_q <= delay_d;
    end
  end

endmodule

@@ sv/wraparound_interval_timer_top.sv @@
`timescale 1ns / 1ps

// Interval timer against a wrapping millisecond uptime: one command beat in, one
// result beat out. A beat is taken every cycle while in_stall_o is low; its
// result goes to the result register, or to the skid while one waits; in_stall_o
// rises only when both are full. All timer state updates as the beat is taken,
// so back-to-back commands see each other's effect. Write periodic_q via
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce this.

module wraparound_interval_timer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wit_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wit_pkg::out_beat_t out_data_o
);
  import wit_pkg::*;

  logic      periodic_q;
  logic      in_acc;
  logic      out_take;
  out_beat_t res;

  logic      out_valid_q, skid_valid_q;
  out_beat_t out_q, skid_q;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  wit_core u_core (
    .clk_i,
    .rst_ni,
    .periodic_i (periodic_q),
    .step_i     (in_acc),
    .beat_i     (in_data_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
    end else if (cfg_we_i) begin
      periodic_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/wit_checker.sv @@
`timescale 1ns / 1ps

module wit_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input wit_pkg::out_beat_t out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // accepted beat always yields a pending result next cycle
  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // input stall only after a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // result valid drops only after a taken beat
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result beat dropped while stalled");

endmodule

bind wraparound_interval_timer_top wit_checker u_wit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
